[rtl/core/bpd_pkg.sv]
// Shared types and constants for the byte-sum packet deframer.
package bpd_pkg;

	localparam int MAX_PAYLOAD_BYTES = 512;
	localparam int HDR_BYTES         = 12;
	localparam int CSUM_BYTES        = 4;
	localparam int EVENT_END         = 8;
	localparam int WORD_BYTES        = 8;
	localparam int CMDQ_DEPTH        = 2;

	localparam int LEN_W      = 10;
	localparam int POS_W      = 10;
	localparam int NB_W       = 4;
	localparam int IDX_W      = $clog2(MAX_PAYLOAD_BYTES);
	localparam int ROWS       = (MAX_PAYLOAD_BYTES + WORD_BYTES - 1) / WORD_BYTES;
	localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = LEN_W'(512);
	localparam logic [LEN_W-1:0] LEN_SAT           = '1;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_CSUM = 2'd1;
	localparam logic [1:0] KIND_LEN  = 2'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       chunk_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [31:0]      event_code;
		logic [LEN_W-1:0] payload_length;
		logic [63:0]      data_word;
		logic [NB_W-1:0]  bytes_valid;
		logic             last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [31:0]      event_code;
		logic [LEN_W-1:0] payload_length;
	} cmd_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} wr_t;

endpackage

[rtl/core/bpd_front.sv]
// Header parser, checksum accumulator and frame classifier.
module bpd_front import bpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             push,
	output cmd_t             push_cmd,
	input  logic             fifo_full,
	input  logic             data_done,
	output wr_t              wr
);

	logic [POS_W-1:0] pos_q;
	logic [31:0]      sum_q;
	logic [31:0]      exp_q;
	logic [31:0]      event_q;
	logic [31:0]      flen_q;
	logic             drop_q;
	logic             busy_q;
	logic [LEN_W-1:0] max_q;

	logic             accept;
	logic             live;
	logic [7:0]       b;
	logic [LEN_W-1:0] limit;
	logic             in_exp;
	logic             in_evt;
	logic             in_len;
	logic             in_pay;
	logic [31:0]      sum_n;
	logic [31:0]      exp_n;
	logic [31:0]      event_n;
	logic [31:0]      flen_n;
	logic [POS_W-1:0] pos_n;
	logic [POS_W-1:0] pay_cnt;
	logic             hdr_done;
	logic             too_big;
	logic             more;
	logic             complete;
	logic             sum_bad;
	logic             err;

	always_comb begin
		in_ready = !fifo_full && !busy_q;
		accept   = in_valid && in_ready;
		live     = accept && !drop_q;
		b        = in_data.rx_byte;
		limit    = (max_q > LEN_W'(MAX_PAYLOAD_BYTES)) ? LEN_W'(MAX_PAYLOAD_BYTES) : max_q;

		in_exp = pos_q < POS_W'(CSUM_BYTES);
		in_evt = !in_exp && (pos_q < POS_W'(EVENT_END));
		in_len = (pos_q >= POS_W'(EVENT_END)) && (pos_q < POS_W'(HDR_BYTES));
		in_pay = pos_q >= POS_W'(HDR_BYTES);

		sum_n   = in_exp ? sum_q : sum_q + {24'b0, b};
		exp_n   = in_exp ? {b, exp_q[31:8]} : exp_q;
		event_n = in_evt ? {b, event_q[31:8]} : event_q;
		flen_n  = in_len ? {b, flen_q[31:8]} : flen_q;

		pos_n    = pos_q + 1'b1;
		pay_cnt  = pos_n - POS_W'(HDR_BYTES);
		hdr_done = pos_n == POS_W'(HDR_BYTES);
		too_big  = hdr_done && (flen_n > 32'(limit));
		more     = hdr_done ? (flen_n != '0)
		                    : ((pos_n < POS_W'(HDR_BYTES)) || (32'(pay_cnt) < flen_q));
		complete = !too_big && !more;
		sum_bad  = sum_n != exp_n;
		err      = too_big || (complete && sum_bad);

		push = live && (too_big || complete);
		priority if (too_big) begin
			push_cmd.kind = KIND_LEN;
		end else if (sum_bad) begin
			push_cmd.kind = KIND_CSUM;
		end else begin
			push_cmd.kind = KIND_DATA;
		end
		push_cmd.event_code     = event_n;
		push_cmd.payload_length = (flen_n > 32'(LEN_SAT)) ? LEN_SAT : flen_n[LEN_W-1:0];

		wr.en   = live && in_pay;
		wr.addr = IDX_W'(pos_q - POS_W'(HDR_BYTES));
		wr.data = b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_q   <= '0;
			exp_q   <= '0;
			event_q <= '0;
			flen_q  <= '0;
			drop_q  <= 1'b0;
			busy_q  <= 1'b0;
			max_q   <= MAX_PAYLOAD_RESET;
		end else begin
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			if (data_done) begin
				busy_q <= 1'b0;
			end else if (push && (push_cmd.kind == KIND_DATA)) begin
				busy_q <= 1'b1;
			end
			if (accept) begin
				if (drop_q) begin
					if (in_data.chunk_end) begin
						drop_q <= 1'b0;
					end
				end else begin
					exp_q   <= exp_n;
					event_q <= event_n;
					flen_q  <= flen_n;
					if (push) begin
						pos_q  <= '0;
						sum_q  <= '0;
						drop_q <= err && !in_data.chunk_end;
					end else begin
						pos_q <= pos_n;
						sum_q <= sum_n;
					end
				end
			end
		end
	end

	// payload buffer must not be overwritten while a frame drains
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !busy_q) else $error("payload write while frame drains");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full) else $error("request pushed into full queue");

endmodule

[rtl/core/bpd_cmd_fifo.sv]
// Short request queue between the parser and the emitter.
module bpd_cmd_fifo import bpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	cmd_t                  entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_PTR_W:0]   cnt_q;

	assign head  = entry_q[rd_ptr_q];
	assign empty = cnt_q == '0;
	assign full  = cnt_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[rtl/core/bpd_back.sv]
// Payload buffer and result emitter, one 8-byte word per cycle while the output is not stalled.
module bpd_back import bpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  wr_t       wr,
	input  cmd_t      cmd,
	input  logic      cmd_valid,
	output logic      pop,
	output logic      data_done,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [63:0]      mem_q [ROWS];
	logic             act_q;
	cmd_t             cur_q;
	logic [LEN_W-1:0] rem_q;
	logic [ROW_W-1:0] row_q;
	logic             rd_v_s1;
	out_item_t        rd_info_s1;
	logic [63:0]      rd_data_s1;
	logic             out_v_q;
	out_item_t        out_q;

	logic             load_out;
	logic             issue;
	logic             is_data;
	logic             word_last;
	logic [NB_W-1:0]  nb;
	logic [ROW_W-1:0] wr_row;
	logic [63:0]      byte_mask;
	out_item_t        out_n;

	always_comb begin
		pop       = cmd_valid && !act_q;
		load_out  = rd_v_s1 && (!out_v_q || out_ready);
		issue     = act_q && (!rd_v_s1 || load_out);
		is_data   = cur_q.kind == KIND_DATA;
		word_last = !is_data || (rem_q <= LEN_W'(WORD_BYTES));
		if (!is_data) begin
			nb = '0;
		end else if (rem_q > LEN_W'(WORD_BYTES)) begin
			nb = NB_W'(WORD_BYTES);
		end else begin
			nb = NB_W'(rem_q);
		end
		data_done = issue && word_last && is_data;
		wr_row    = ROW_W'(wr.addr >> 3);
		for (int i = 0; i < WORD_BYTES; i++) begin
			byte_mask[i*8 +: 8] = (NB_W'(i) < rd_info_s1.bytes_valid) ? 8'hFF : 8'h00;
		end
		out_n           = rd_info_s1;
		out_n.data_word = rd_data_s1 & byte_mask;
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr_row][{wr.addr[2:0], 3'b000} +: 8] <= wr.data;
		end
		if (issue) begin
			rd_data_s1 <= mem_q[row_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			rd_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				act_q <= 1'b1;
			end else if (issue && word_last) begin
				act_q <= 1'b0;
			end
			if (issue) begin
				rd_v_s1 <= 1'b1;
			end else if (load_out) begin
				rd_v_s1 <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= cmd;
			rem_q <= cmd.payload_length;
			row_q <= '0;
		end else if (issue) begin
			rem_q <= rem_q - LEN_W'(WORD_BYTES);
			row_q <= row_q + 1'b1;
		end
		if (issue) begin
			rd_info_s1.kind           <= cur_q.kind;
			rd_info_s1.event_code     <= cur_q.event_code;
			rd_info_s1.payload_length <= cur_q.payload_length;
			rd_info_s1.data_word      <= '0;
			rd_info_s1.bytes_valid    <= nb;
			rd_info_s1.last           <= word_last;
		end
		if (load_out) begin
			out_q <= out_n;
		end
	end

	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_v_s1 && !load_out) |=> (rd_v_s1 && (rd_data_s1 === $past(rd_data_s1))))
		else $error("read word lost while output stalled");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && (out_q.kind != KIND_DATA)) |-> (out_q.last && (out_q.bytes_valid == '0)))
		else $error("error result not a single empty word");

endmodule

[rtl/core/bytesum_packet_deframer_unit.sv]
// Byte-sum packet deframer: one received byte per cycle in unless stalled, 8-byte payload words out.
// Throughput: one byte per cycle while not stalled; payload words leave one per cycle unless out_ready is low.
// A frame's first result passes the request queue, emitter active flag, read register and output register.
// Input stalls from a good frame's end until its last row is read.
// Errors pass through a 2-entry request queue; the parser also stalls while it is full.
// Reset clears all control state and sets max_payload to 512; the payload buffer is not cleared.
module bytesum_packet_deframer_unit import bpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	logic push;
	cmd_t push_cmd;
	logic pop;
	cmd_t head;
	logic empty;
	logic full;
	logic data_done;
	wr_t  wr;

	bpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.push        (push),
		.push_cmd    (push_cmd),
		.fifo_full   (full),
		.data_done   (data_done),
		.wr          (wr)
	);

	bpd_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	bpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.cmd       (head),
		.cmd_valid (!empty),
		.pop       (pop),
		.data_done (data_done),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[bench/bpd_frame_checker.sv]
// Monitor for the byte-sum packet deframer: predicts every result word and compares it.
module bpd_frame_checker import bpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_item_t         in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_item_t        out_data,
	output int               fail_count,
	output int               words_owed,
	output logic             parser_at_start
);

	logic [LEN_W-1:0] limit_reg;
	logic [31:0]      hdr_sum;
	logic [31:0]      hdr_event;
	logic [31:0]      hdr_len;
	logic [31:0]      byte_total;
	logic [POS_W-1:0] frame_pos;
	logic             dropping_now;
	logic [7:0]       payload_mem [MAX_PAYLOAD_BYTES];
	out_item_t        owed_q [$];

	task automatic owe(input logic [1:0] kind, input logic [LEN_W-1:0] len,
			input logic [63:0] word, input logic [NB_W-1:0] nb, input logic last);
		out_item_t r;
		r.kind           = kind;
		r.event_code     = hdr_event;
		r.payload_length = len;
		r.data_word      = word;
		r.bytes_valid    = nb;
		r.last           = last;
		owed_q.push_back(r);
	endtask

	task automatic close_frame(input logic err, input logic ce);
		frame_pos    = '0;
		byte_total   = '0;
		dropping_now = err && !ce;
	endtask

	task automatic deframe_byte(input in_item_t it);
		logic [POS_W-1:0] p;
		logic [63:0]      w;
		int unsigned      cap;
		int unsigned      done;
		int unsigned      n;
		if (dropping_now) begin
			if (it.chunk_end)
				close_frame(1'b0, 1'b1);
			return;
		end
		p = frame_pos;
		if (p >= CSUM_BYTES)
			byte_total += it.rx_byte;
		if (p < CSUM_BYTES)
			hdr_sum = {it.rx_byte, hdr_sum[31:8]};
		else if (p < EVENT_END)
			hdr_event = {it.rx_byte, hdr_event[31:8]};
		else if (p < HDR_BYTES)
			hdr_len = {it.rx_byte, hdr_len[31:8]};
		else
			payload_mem[p - HDR_BYTES] = it.rx_byte;
		p++;
		if (p == HDR_BYTES) begin
			cap = (limit_reg > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES : limit_reg;
			if (hdr_len > cap) begin
				owe(KIND_LEN, (hdr_len > 1023) ? LEN_SAT : hdr_len[LEN_W-1:0],
					'0, '0, 1'b1);
				close_frame(1'b1, it.chunk_end);
				return;
			end
			if (hdr_len != 0) begin
				frame_pos = p;
				return;
			end
		end else if (p < HDR_BYTES || (p - HDR_BYTES) < hdr_len) begin
			frame_pos = p;
			return;
		end
		if (byte_total != hdr_sum) begin
			owe(KIND_CSUM, hdr_len[LEN_W-1:0], '0, '0, 1'b1);
			close_frame(1'b1, it.chunk_end);
			return;
		end
		if (hdr_len == 0) begin
			owe(KIND_DATA, '0, '0, '0, 1'b1);
		end else begin
			done = 0;
			while (done < hdr_len) begin
				n = (hdr_len - done > WORD_BYTES) ? WORD_BYTES : hdr_len - done;
				w = '0;
				for (int i = 0; i < n; i++)
					w[8*i +: 8] = payload_mem[done + i];
				done += n;
				owe(KIND_DATA, hdr_len[LEN_W-1:0], w, n[NB_W-1:0], done == hdr_len);
			end
		end
		close_frame(1'b0, it.chunk_end);
	endtask

	task automatic check_word(input out_item_t got);
		out_item_t want;
		if (owed_q.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: result with none owed: %h", $time, got);
			return;
		end
		want = owed_q.pop_front();
		if (got.kind !== want.kind || got.event_code !== want.event_code ||
				got.payload_length !== want.payload_length ||
				got.data_word !== want.data_word ||
				got.bytes_valid !== want.bytes_valid || got.last !== want.last) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("%0t: exp kind %0d event %h len %0d word %h nb %0d last %0b",
					$time, want.kind, want.event_code, want.payload_length,
					want.data_word, want.bytes_valid, want.last);
				$display("%0t: got kind %0d event %h len %0d word %h nb %0d last %0b",
					$time, got.kind, got.event_code, got.payload_length,
					got.data_word, got.bytes_valid, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_reg    = MAX_PAYLOAD_RESET;
			hdr_sum      = '0;
			hdr_event    = '0;
			hdr_len      = '0;
			byte_total   = '0;
			frame_pos    = '0;
			dropping_now = 1'b0;
			fail_count   = 0;
			owed_q.delete();
		end else begin
			if (cfg_wr_en)
				limit_reg = cfg_wr_data;
			if (in_valid && in_ready)
				deframe_byte(in_data);
			if (out_valid && out_ready)
				check_word(out_data);
		end
		words_owed      = owed_q.size();
		parser_at_start = (frame_pos == '0) && !dropping_now;
	end

endmodule

[bench/tb_bytesum_packet_deframer_unit.sv]
// Testbench top for the byte-sum packet deframer: clock, reset, stimulus and verdict.
module tb_bytesum_packet_deframer_unit;
	import bpd_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 12;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [LEN_W-1:0] cfg_wr_data;
	logic             in_valid;
	logic             in_ready;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_ready;
	out_item_t        out_data;
	int               fail_count;
	int               words_owed;
	logic             parser_at_start;
	logic             hold_toggle = 1'b0;
	int               burst_left  = 0;
	int               frame_bytes = 0;
	logic [LEN_W-1:0] cur_limit;

	always #6 clk = ~clk;

	bytesum_packet_deframer_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

	bpd_frame_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.fail_count      (fail_count),
		.words_owed      (words_owed),
		.parser_at_start (parser_at_start)
	);

	initial begin
		#(12 * 500000);
		$display("TB_ERROR");
		$finish;
	end

	// receiver: own stall pattern, plus a long hold-off on request
	initial begin
		int   run_left;
		int   mode;
		logic hold_seen;
		run_left  = 0;
		mode      = 0;
		hold_seen = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (run_left == 0) begin
					mode     = $urandom_range(0, 2);
					run_left = $urandom_range(4, 48);
				end
				run_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// one request per byte; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic ce);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
		end else begin
			gap = 0;
		end
		burst_left--;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{rx_byte: b, chunk_end: ce};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		wait (words_owed == 0);
		@(negedge clk);
	endtask

	task automatic set_max_payload(input logic [LEN_W-1:0] v);
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_limit = v;
	endtask

	// feed chunk-ending bytes until the parser is back at a header start
	task automatic sync_parser();
		while (!parser_at_start)
			send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// keep > 0 cuts the frame after that many bytes
	task automatic send_frame(input logic [31:0] plen, input logic [31:0] evt,
			input bit bad_sum, input int ce_pct, input bit end_ce, input int keep);
		logic [7:0]  body [$];
		logic [31:0] sum;
		logic [7:0]  b;
		int          n;
		sum = '0;
		for (int i = 0; i < 4; i++)
			body.push_back(evt[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			body.push_back(plen[8*i +: 8]);
		if (plen <= MAX_PAYLOAD_BYTES)
			repeat (plen) body.push_back(8'($urandom_range(0, 255)));
		foreach (body[i])
			sum += body[i];
		if (bad_sum)
			sum ^= 32'd1 << $urandom_range(0, 31);
		n = 4 + body.size();
		if (keep > 0 && keep < n)
			n = keep;
		for (int i = 0; i < n; i++) begin
			b = (i < 4) ? sum[8*i +: 8] : body[i-4];
			send_byte(b, (i == n - 1 && end_ce) || ($urandom_range(0, 99) < ce_pct));
		end
		frame_bytes += n;
	endtask

	function automatic logic [31:0] pick_len(input int cap);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return (cap < 64) ? cap : 64;
		if (r < 3)
			return 0;
		return $urandom_range(0, (cap < 40) ? cap : 40);
	endfunction

	task automatic random_phase(input int target);
		int          stop_at;
		int          pick;
		int          cap;
		logic [31:0] plen;
		cap     = (cur_limit > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES : cur_limit;
		stop_at = frame_bytes + target;
		while (frame_bytes < stop_at) begin
			sync_parser();
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				send_frame(pick_len(cap), $urandom, pick < 8,
					$urandom_range(0, 1) ? 0 : 10, $urandom_range(0, 3) == 0, 0);
			end else if (pick < 82) begin
				send_frame(cap + 1 + $urandom_range(0, 600), $urandom, 1'b0, 10,
					1'($urandom_range(0, 1)), HDR_BYTES);
			end else if (pick < 90) begin
				plen = pick_len(cap);
				send_frame(plen, $urandom, 1'b0, 10, 1'b0, $urandom_range(1, 11 + plen));
			end else begin
				repeat ($urandom_range(1, 16))
					send_byte(8'($urandom), $urandom_range(0, 7) == 0);
			end
		end
		sync_parser();
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		cur_limit   = MAX_PAYLOAD_RESET;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_frame(0, 32'h0000_0000, 1'b0, 0, 1'b0, 0);
		send_frame(1, 32'hFFFF_FFFF, 1'b0, 50, 1'b0, 0);
		send_frame(8, $urandom, 1'b0, 0, 1'b1, 0);
		send_frame(9, $urandom, 1'b0, 0, 1'b0, 0);
		// sum mismatch mid-chunk: rest of chunk is dropped
		send_frame(3, $urandom, 1'b1, 0, 1'b0, 0);
		repeat (3) send_byte(8'($urandom), 1'b0);
		sync_parser();
		// mismatch on the chunk's final byte: no drop
		send_frame(2, $urandom, 1'b1, 0, 1'b1, 0);
		send_frame(0, $urandom, 1'b1, 0, 1'b1, 0);
		send_frame(513, $urandom, 1'b0, 0, 1'b0, HDR_BYTES);
		repeat (2) send_byte(8'($urandom), 1'b0);
		sync_parser();
		send_frame(32'hFFFF_FFFF, $urandom, 1'b0, 0, 1'b1, HDR_BYTES);
		send_frame(1000, $urandom, 1'b0, 0, 1'b1, HDR_BYTES);
		send_frame(1023, $urandom, 1'b0, 0, 1'b1, HDR_BYTES);
		send_frame(1024, $urandom, 1'b0, 0, 1'b1, HDR_BYTES);

		set_max_payload('0);
		send_frame(0, $urandom, 1'b0, 0, 1'b0, 0);
		send_frame(1, $urandom, 1'b0, 0, 1'b1, HDR_BYTES);

		// limit beyond the buffer behaves as the buffer size
		set_max_payload('1);
		send_frame(64, $urandom, 1'b0, 0, 1'b0, 0);
		send_frame(513, $urandom, 1'b0, 0, 1'b1, HDR_BYTES);
		random_phase(16);

		// receiver holds off while requests keep coming
		drain_results();
		hold_toggle <= ~hold_toggle;
		repeat (2) send_frame(16, $urandom, 1'b0, 0, 1'b0, 0);

		set_max_payload(10'd8);
		random_phase(16);
		set_max_payload(10'd1);
		random_phase(16);
		set_max_payload(LEN_W'($urandom_range(2, 511)));
		random_phase(16);
		set_max_payload(MAX_PAYLOAD_RESET);
		random_phase(16);

		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && words_owed == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
